### rtl/core/rhd_pkg.sv
// Package: widths, register indexes, microcode word format and program ROM.
package rhd_pkg;

   localparam int MAX_SENSORS = 16;
   localparam int TEMP_W      = 15;
   localparam int AGE_W       = 16;
   localparam int CNT_W       = $clog2(MAX_SENSORS + 1);
   localparam int SUM_W       = TEMP_W + $clog2(MAX_SENSORS) + 1;
   localparam int BAND_W      = 10;
   localparam int PRIO_W      = 8;
   localparam int DEMAND_W    = 32;
   localparam int MAG_W       = TEMP_W;
   localparam int FRAC_W      = 8;
   localparam int DIV_W       = MAG_W + FRAC_W;
   localparam int DCNT_W      = $clog2(DIV_W + 1);
   localparam int ACC_W       = 2 * DIV_W;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int PC_W        = 4;

   // register indexes on the CSR port
   localparam logic [CSR_ADDR_W-1:0] CSR_MODE     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BELOW    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ABOVE    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_PRIO     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRESH    = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_FROST    = 3'd6;

   // register reset values
   localparam logic                 MODE_RST   = 1'b0;
   localparam logic [TEMP_W-1:0]    TARGET_RST = 15'd2200;
   localparam logic [BAND_W-1:0]    BELOW_RST  = 10'd50;
   localparam logic [BAND_W-1:0]    ABOVE_RST  = 10'd50;
   localparam logic [PRIO_W-1:0]    PRIO_RST   = 8'd5;
   localparam logic [AGE_W-1:0]     FRESH_RST  = 16'd60;
   localparam logic [TEMP_W-1:0]    FROST_RST  = 15'd500;

   localparam logic MODE_ANTIFREEZE = 1'b1;

   // coefficient of one in Q.8
   localparam logic [DIV_W-1:0] COEF_ONE = DIV_W'(1 << FRAC_W);

   localparam logic [DEMAND_W-1:0] DEMAND_MAX = {1'b0, {(DEMAND_W-1){1'b1}}};
   localparam logic [DEMAND_W-1:0] DEMAND_MIN = {1'b1, {(DEMAND_W-1){1'b0}}};

   typedef enum logic [3:0] {
      OP_NOP,
      OP_AVG_LOAD,
      OP_DIV_STEP,
      OP_AVG_STORE,
      OP_DEV,
      OP_COEF_LOAD,
      OP_COEF,
      OP_MUL_PRIO,
      OP_SAT,
      OP_FROST,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      JMP_NEVER,
      JMP_ALWAYS,
      JMP_CNT_ZERO,
      JMP_DIV_MORE,
      JMP_ANTIFREEZE,
      JMP_COEF_SMALL,
      JMP_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_W-1:0]     target;
   } ucode_word_type;

   // program addresses
   localparam logic [PC_W-1:0] STEP_AVG_LOAD  = 4'd0;
   localparam logic [PC_W-1:0] STEP_AVG_DIV   = 4'd1;
   localparam logic [PC_W-1:0] STEP_AVG_STORE = 4'd2;
   localparam logic [PC_W-1:0] STEP_DEV       = 4'd3;
   localparam logic [PC_W-1:0] STEP_COEF_LOAD = 4'd4;
   localparam logic [PC_W-1:0] STEP_COEF_DIV  = 4'd5;
   localparam logic [PC_W-1:0] STEP_COEF      = 4'd6;
   localparam logic [PC_W-1:0] STEP_MUL_PRIO  = 4'd7;
   localparam logic [PC_W-1:0] STEP_SAT       = 4'd8;
   localparam logic [PC_W-1:0] STEP_FROST     = 4'd9;
   localparam logic [PC_W-1:0] STEP_EMIT      = 4'd10;

   function automatic ucode_word_type rhd_ucode(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      w = '{op: OP_NOP, cond: JMP_NEVER, target: STEP_AVG_LOAD};
      case (pc)
         STEP_AVG_LOAD:  w = '{op: OP_AVG_LOAD,  cond: JMP_CNT_ZERO,   target: STEP_DEV};
         STEP_AVG_DIV:   w = '{op: OP_DIV_STEP,  cond: JMP_DIV_MORE,   target: STEP_AVG_DIV};
         STEP_AVG_STORE: w = '{op: OP_AVG_STORE, cond: JMP_NEVER,      target: STEP_AVG_LOAD};
         STEP_DEV:       w = '{op: OP_DEV,       cond: JMP_ANTIFREEZE, target: STEP_FROST};
         STEP_COEF_LOAD: w = '{op: OP_COEF_LOAD, cond: JMP_NEVER,      target: STEP_AVG_LOAD};
         STEP_COEF_DIV:  w = '{op: OP_DIV_STEP,  cond: JMP_DIV_MORE,   target: STEP_COEF_DIV};
         STEP_COEF:      w = '{op: OP_COEF,      cond: JMP_COEF_SMALL, target: STEP_SAT};
         STEP_MUL_PRIO:  w = '{op: OP_MUL_PRIO,  cond: JMP_NEVER,      target: STEP_AVG_LOAD};
         STEP_SAT:       w = '{op: OP_SAT,       cond: JMP_ALWAYS,     target: STEP_EMIT};
         STEP_FROST:     w = '{op: OP_FROST,     cond: JMP_NEVER,      target: STEP_AVG_LOAD};
         STEP_EMIT:      w = '{op: OP_EMIT,      cond: JMP_OUT_BUSY,   target: STEP_EMIT};
         default:        w = '{op: OP_NOP,       cond: JMP_NEVER,      target: STEP_AVG_LOAD};
      endcase
      return w;
   endfunction

endpackage

### rtl/core/rhd_if.sv
// Interfaces: reading request channel, demand response channel, CSR write channel.
interface rhd_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [rhd_pkg::TEMP_W-1:0] reading_temp;
   logic [rhd_pkg::AGE_W-1:0]        reading_age;
   logic                             has_reading;
   logic                             last_item;

   modport source (output valid, reading_temp, reading_age, has_reading, last_item,
                   input ready);
   modport sink   (input valid, reading_temp, reading_age, has_reading, last_item,
                   output ready);
endinterface

interface rhd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rhd_pkg::DEMAND_W-1:0] demand;
   logic signed [rhd_pkg::TEMP_W-1:0]   room_temp;
   logic [rhd_pkg::CNT_W-1:0]          fresh_count;

   modport source (output valid, demand, room_temp, fresh_count, input ready);
   modport sink   (input valid, demand, room_temp, fresh_count, output ready);
endinterface

interface rhd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [rhd_pkg::CSR_ADDR_W-1:0]     addr;
   logic [rhd_pkg::CSR_DATA_W-1:0]     wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

### rtl/core/room_heating_demand_core.sv
// Room heating demand core: fresh-reading average and Q.8 demand via a microcoded datapath.
//
// Readings of one room arrive as requests on req_ch; each accepted one is,
// if fresh (has_reading, age below fresh_ff, fewer than 16 counted), added to a
// running sum. The request marked last_item starts a short microprogram held in a ROM
// (rhd_pkg::rhd_ucode): one shared restoring divider, one quotient bit per cycle and
// 23 bits in all, forms the truncated average, and in regulate mode the same divider
// forms the Q.8 coefficient |room - target| * 256 / band; a multiplier then gives the
// demand, which saturates to 32 bits. A coefficient above one takes an extra step for
// the priority multiply; antifreeze mode skips the coefficient steps, and the average
// division is skipped when no reading was fresh.
// req_ch.ready is low while the program runs; a finished response sits in an output
// register, so the next room's readings are taken while it waits. CSR writes (csr_ch,
// always ready) go to the registers in package order and are meant to happen only
// while the core is idle.
module room_heating_demand_core import rhd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rhd_req_if.sink    req_ch,
   rhd_rsp_if.source  rsp_ch,
   rhd_csr_if.sink    csr_ch
);

   // configuration registers
   logic              mode_ff,   mode_in;
   logic [TEMP_W-1:0] target_ff, target_in;
   logic [BAND_W-1:0] below_ff,  below_in;
   logic [BAND_W-1:0] above_ff,  above_in;
   logic [PRIO_W-1:0] prio_ff,   prio_in;
   logic [AGE_W-1:0]  fresh_ff,  fresh_in;
   logic [TEMP_W-1:0] frost_ff,  frost_in;

   // accumulation
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // sequencer
   logic              busy_ff, busy_in;
   logic [PC_W-1:0]   pc_ff,   pc_in;
   ucode_word_type    uw;
   logic              take_jump;

   // datapath
   logic [BAND_W-1:0]   rem_ff,  rem_in;
   logic [DIV_W-1:0]    quo_ff,  quo_in;
   logic [BAND_W-1:0]   dvsr_ff, dvsr_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic                neg_ff,  neg_in;
   logic [TEMP_W-1:0]   room_ff, room_in;
   logic [MAG_W-1:0]    mag_ff,  mag_in;
   logic [ACC_W-1:0]    acc_ff,  acc_in;
   logic [DEMAND_W-1:0] dmd_ff,  dmd_in;

   // output register
   logic                out_vld_ff, out_vld_in;
   logic [DEMAND_W-1:0] out_dmd_ff, out_dmd_in;
   logic [TEMP_W-1:0]   out_room_ff, out_room_in;
   logic [CNT_W-1:0]    out_cnt_ff, out_cnt_in;

   // helpers
   logic                   req_acc;
   logic                   fresh;
   logic                   out_free;
   logic [SUM_W-1:0]       sum_abs;
   logic [BAND_W:0]        div_shift;
   logic                   div_bit;
   logic [TEMP_W:0]        dev;
   logic [TEMP_W:0]        dev_neg;
   logic [BAND_W-1:0]      band;
   logic [TEMP_W-1:0]      room_neg;
   logic [ACC_W-1:0]       sq;
   logic [DIV_W+PRIO_W-1:0] cp;
   logic [ACC_W+PRIO_W-1:0] ap;
   logic                   room_lt_frost;

   assign req_ch.ready = !busy_ff;
   assign csr_ch.ready = 1'b1;
   assign req_acc      = req_ch.valid && !busy_ff;
   assign out_free     = !out_vld_ff || rsp_ch.ready;

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.demand      = out_dmd_ff;
   assign rsp_ch.room_temp   = out_room_ff;
   assign rsp_ch.fresh_count = out_cnt_ff;

   assign uw = rhd_ucode(pc_ff);

   // jump condition
   always_comb begin
      case (uw.cond)
         JMP_NEVER:      take_jump = 1'b0;
         JMP_ALWAYS:     take_jump = 1'b1;
         JMP_CNT_ZERO:   take_jump = (cnt_ff == '0);
         JMP_DIV_MORE:   take_jump = (dcnt_ff != DCNT_W'(1));
         JMP_ANTIFREEZE: take_jump = (mode_ff == MODE_ANTIFREEZE);
         JMP_COEF_SMALL: take_jump = (quo_ff <= COEF_ONE);
         JMP_OUT_BUSY:   take_jump = !out_free;
         default:        take_jump = 1'b0;
      endcase
   end

   // datapath arithmetic
   assign fresh     = req_ch.has_reading && (req_ch.reading_age < fresh_ff) &&
                      (cnt_ff < CNT_W'(MAX_SENSORS));
   assign sum_abs   = sum_ff[SUM_W-1] ? (SUM_W'(0) - sum_ff) : sum_ff;
   assign div_shift = {rem_ff, quo_ff[DIV_W-1]};
   assign div_bit   = (div_shift >= {1'b0, dvsr_ff});
   assign dev       = {room_ff[TEMP_W-1], room_ff} - {target_ff[TEMP_W-1], target_ff};
   assign dev_neg   = (TEMP_W+1)'(0) - dev;
   assign band      = neg_ff ? below_ff : above_ff;
   assign room_neg  = TEMP_W'(0) - quo_ff[TEMP_W-1:0];
   assign sq        = quo_ff * quo_ff;
   assign cp        = quo_ff * prio_ff;
   assign ap        = acc_ff * prio_ff;
   assign room_lt_frost = ($signed(room_ff) < $signed(frost_ff));

   always_comb begin
      mode_in     = mode_ff;
      target_in   = target_ff;
      below_in    = below_ff;
      above_in    = above_ff;
      prio_in     = prio_ff;
      fresh_in    = fresh_ff;
      frost_in    = frost_ff;
      sum_in      = sum_ff;
      cnt_in      = cnt_ff;
      busy_in     = busy_ff;
      pc_in       = pc_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dvsr_in     = dvsr_ff;
      dcnt_in     = dcnt_ff;
      neg_in      = neg_ff;
      room_in     = room_ff;
      mag_in      = mag_ff;
      acc_in      = acc_ff;
      dmd_in      = dmd_ff;
      out_vld_in  = out_vld_ff && !rsp_ch.ready;
      out_dmd_in  = out_dmd_ff;
      out_room_in = out_room_ff;
      out_cnt_in  = out_cnt_ff;

      // CSR writes; unknown indexes are dropped
      if (csr_ch.valid) begin
         case (csr_ch.addr)
            CSR_MODE:   mode_in   = csr_ch.wdata[0];
            CSR_TARGET: target_in = csr_ch.wdata[TEMP_W-1:0];
            CSR_BELOW:  below_in  = csr_ch.wdata[BAND_W-1:0];
            CSR_ABOVE:  above_in  = csr_ch.wdata[BAND_W-1:0];
            CSR_PRIO:   prio_in   = csr_ch.wdata[PRIO_W-1:0];
            CSR_FRESH:  fresh_in  = csr_ch.wdata[AGE_W-1:0];
            CSR_FROST:  frost_in  = csr_ch.wdata[TEMP_W-1:0];
            default:    ;
         endcase
      end

      // accumulate fresh readings; last item kicks off the program
      if (req_acc) begin
         if (fresh) begin
            sum_in = sum_ff + {{(SUM_W-TEMP_W){req_ch.reading_temp[TEMP_W-1]}},
                               req_ch.reading_temp};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         if (req_ch.last_item) begin
            busy_in = 1'b1;
            pc_in   = STEP_AVG_LOAD;
         end
      end

      if (busy_ff) begin
         pc_in = take_jump ? uw.target : pc_ff + PC_W'(1);
         case (uw.op)
            OP_AVG_LOAD: begin
               room_in = '0;   // stays zero when nothing was fresh
               neg_in  = sum_ff[SUM_W-1];
               quo_in  = DIV_W'(sum_abs);
               rem_in  = '0;
               dvsr_in = BAND_W'(cnt_ff);
               dcnt_in = DCNT_W'(DIV_W);
            end
            OP_DIV_STEP: begin
               rem_in  = div_bit ? BAND_W'(div_shift - {1'b0, dvsr_ff})
                                 : div_shift[BAND_W-1:0];
               quo_in  = {quo_ff[DIV_W-2:0], div_bit};
               dcnt_in = dcnt_ff - DCNT_W'(1);
            end
            OP_AVG_STORE: begin
               room_in = neg_ff ? room_neg : quo_ff[TEMP_W-1:0];
            end
            OP_DEV: begin
               neg_in = dev[TEMP_W];
               mag_in = dev[TEMP_W] ? dev_neg[MAG_W-1:0] : dev[MAG_W-1:0];
            end
            OP_COEF_LOAD: begin
               quo_in  = {mag_ff, {FRAC_W{1'b0}}};
               rem_in  = '0;
               dvsr_in = (band == '0) ? BAND_W'(1) : band;
               dcnt_in = DCNT_W'(DIV_W);
            end
            OP_COEF: begin
               // up to one: c * prio; above one: c * c now, prio next step
               acc_in = (quo_ff <= COEF_ONE) ? ACC_W'(cp) : sq;
            end
            OP_MUL_PRIO: begin
               acc_in = ap[ACC_W+PRIO_W-1:FRAC_W];
            end
            OP_SAT: begin
               if (neg_ff) begin
                  dmd_in = (acc_ff > ACC_W'(DEMAND_MIN)) ? DEMAND_MIN
                                                          : DEMAND_W'(0) - acc_ff[DEMAND_W-1:0];
               end else begin
                  dmd_in = (acc_ff > ACC_W'(DEMAND_MAX)) ? DEMAND_MAX
                                                          : acc_ff[DEMAND_W-1:0];
               end
            end
            OP_FROST: begin
               dmd_in = room_lt_frost ? DEMAND_MAX : '0;
            end
            OP_EMIT: begin
               if (out_free) begin
                  out_vld_in  = 1'b1;
                  out_dmd_in  = dmd_ff;
                  out_room_in = room_ff;
                  out_cnt_in  = cnt_ff;
                  sum_in      = '0;
                  cnt_in      = '0;
                  busy_in     = 1'b0;
                  pc_in       = STEP_AVG_LOAD;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_RST;
         target_ff  <= TARGET_RST;
         below_ff   <= BELOW_RST;
         above_ff   <= ABOVE_RST;
         prio_ff    <= PRIO_RST;
         fresh_ff   <= FRESH_RST;
         frost_ff   <= FROST_RST;
         sum_ff     <= '0;
         cnt_ff     <= '0;
         busy_ff    <= 1'b0;
         pc_ff      <= STEP_AVG_LOAD;
         out_vld_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         target_ff  <= target_in;
         below_ff   <= below_in;
         above_ff   <= above_in;
         prio_ff    <= prio_in;
         fresh_ff   <= fresh_in;
         frost_ff   <= frost_in;
         sum_ff     <= sum_in;
         cnt_ff     <= cnt_in;
         busy_ff    <= busy_in;
         pc_ff      <= pc_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dvsr_ff     <= dvsr_in;
      dcnt_ff     <= dcnt_in;
      neg_ff      <= neg_in;
      room_ff     <= room_in;
      mag_ff      <= mag_in;
      acc_ff      <= acc_in;
      dmd_ff      <= dmd_in;
      out_dmd_ff  <= out_dmd_in;
      out_room_ff <= out_room_in;
      out_cnt_ff  <= out_cnt_in;
   end

endmodule
